@@ hw/rtl/tsms_pkg.sv @@
// ----------------------------------------------------------------------------
// tsms_pkg: shared types and constants for timestamp_to_milliseconds
// Register indexes and the widths of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package tsms_pkg;
  localparam int StampW = 64;
  localparam int DivW = 40;
  localparam int ScaleW = 31;
  localparam int IdxW = 2;
  localparam logic [9:0] MsPerSecond = 10'd1000;

  typedef enum logic [IdxW-1:0] {
    REG_DIVISOR = 2'd0,
    REG_MODE    = 2'd1,
    REG_SCALE   = 2'd2,
    REG_ORIGIN  = 2'd3
  } reg_idx_t;
endpackage
`default_nettype wire

@@ hw/rtl/timestamp_to_milliseconds.sv @@
// ----------------------------------------------------------------------------
// timestamp_to_milliseconds
// Converts a raw counter timestamp to milliseconds since a configured origin.
// ----------------------------------------------------------------------------
// A timestamp may be started in every cycle; busy is always low. Each result
// appears on elapsed_ms with done high for one cycle, after the start passes
// through 64 restoring-divide stages for timestamp / time_divisor (one
// quotient bit each), 64 restoring stages dividing the remainder by
// scale_value for mode 1 (the remainder is the whole timestamp when
// time_divisor is zero), then 3 stages to scale, sum and subtract the origin.
// Register writes take effect at once; issue them only while no timestamp is
// in flight. The receiver cannot stall results.
`default_nettype none
module timestamp_to_milliseconds (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] raw_timestamp,
  output logic             done,
  output logic [63:0]      elapsed_ms,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int N = tsms_pkg::StampW;
  localparam int RW = tsms_pkg::DivW;
  localparam int SW = tsms_pkg::ScaleW;

  logic [RW-1:0] time_divisor;
  logic          scale_mode;
  logic [SW-1:0] scale_value;
  logic [63:0]   time_origin;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_divisor <= RW'(1);
      scale_mode <= 1'b0;
      scale_value <= SW'(1);
      time_origin <= '0;
    end else if (cfg_valid) begin
      unique case (tsms_pkg::reg_idx_t'(cfg_index))
        tsms_pkg::REG_DIVISOR: time_divisor <= cfg_data[RW-1:0];
        tsms_pkg::REG_MODE:    scale_mode <= cfg_data[0];
        tsms_pkg::REG_SCALE:   scale_value <= cfg_data[SW-1:0];
        tsms_pkg::REG_ORIGIN:  time_origin <= cfg_data;
        default: ;
      endcase
    end
  end

  // first divider: one quotient bit per stage, dividend rotates msb first
  logic          v1 [N+1];
  logic [RW:0]   rem1 [N+1];
  logic [N-1:0]  num1 [N+1];
  logic [N-1:0]  quo1 [N+1];

  assign v1[0] = start;
  assign rem1[0] = '0;
  assign num1[0] = raw_timestamp;
  assign quo1[0] = '0;

  for (genvar s = 0; s < N; s++) begin : g_div1
    logic [RW+1:0] trial;
    logic [RW:0]   shifted;
    assign shifted = {rem1[s][RW-1:0], num1[s][N-1]};
    assign trial = {1'b0, shifted} - {2'b0, time_divisor};
    always_ff @(posedge clk) begin
      if (rst) v1[s+1] <= 1'b0;
      else v1[s+1] <= v1[s];
      num1[s+1] <= {num1[s][N-2:0], num1[s][N-1]};
      if (!trial[RW+1]) begin
        rem1[s+1] <= trial[RW:0];
        quo1[s+1] <= {quo1[s][N-2:0], 1'b1};
      end else begin
        rem1[s+1] <= shifted;
        quo1[s+1] <= {quo1[s][N-2:0], 1'b0};
      end
    end
  end

  // zero divisor leaves the whole timestamp as remainder
  logic [N-1:0]  frac0;
  assign frac0 = (time_divisor == '0) ? num1[N] : {{(N-RW){1'b0}}, rem1[N][RW-1:0]};

  // second divider over the remainder, 64 stages, fed from the first
  localparam int M = N;
  logic          v2 [M+1];
  logic [SW:0]   rem2 [M+1];
  logic [M-1:0]  num2 [M+1];
  logic [M-1:0]  quo2 [M+1];
  logic [63:0]   sec2 [M+1];

  assign v2[0] = v1[N];
  assign rem2[0] = '0;
  assign num2[0] = frac0;
  assign quo2[0] = '0;
  assign sec2[0] = quo1[N];

  for (genvar s = 0; s < M; s++) begin : g_div2
    logic [SW+1:0] trial;
    logic [SW:0]   shifted;
    assign shifted = {rem2[s][SW-1:0], num2[s][M-1]};
    assign trial = {1'b0, shifted} - {2'b0, scale_value};
    always_ff @(posedge clk) begin
      if (rst) v2[s+1] <= 1'b0;
      else v2[s+1] <= v2[s];
      num2[s+1] <= {num2[s][M-2:0], 1'b0};
      sec2[s+1] <= sec2[s];
      if (!trial[SW+1]) begin
        rem2[s+1] <= trial[SW:0];
        quo2[s+1] <= {quo2[s][M-2:0], 1'b1};
      end else begin
        rem2[s+1] <= shifted;
        quo2[s+1] <= {quo2[s][M-2:0], 1'b0};
      end
    end
  end

  // carry the remainder alongside the second divider for mode 0
  logic [N-1:0]  frac_d [M+1];
  assign frac_d[0] = frac0;
  for (genvar s = 0; s < M; s++) begin : g_frac
    always_ff @(posedge clk) frac_d[s+1] <= frac_d[s];
  end

  // back end: multiply, sum, subtract
  logic          va, vb, vc;
  logic [63:0]   sec_ms_a, sub_a, ms_b;
  logic [62:0]   prod_lo_a;
  logic [31:0]   prod_hi_a;

  // zero scale yields an all-ones quotient from the restoring stages
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= v2[M];
      vb <= va;
      vc <= vb;
    end
    sec_ms_a <= 64'(sec2[M] * 64'(tsms_pkg::MsPerSecond));
    prod_lo_a <= frac_d[M][31:0] * scale_value;
    prod_hi_a <= 32'(frac_d[M][63:32] * scale_value);
    sub_a <= quo2[M];
    ms_b <= sec_ms_a + (scale_mode ? sub_a : ({1'b0, prod_lo_a} + {prod_hi_a, 32'd0}));
    elapsed_ms <= ms_b - time_origin;
  end

  assign done = vc;

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    v1[N] |-> ##(M+3) done) else $error("result lost in pipeline");
  a_ready: assert property (@(posedge clk) cfg_ready)
    else $error("config channel stalled");
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for timestamp_to_milliseconds
// Drives raw timestamps and register writes from a queue of pending
// operations. It predicts each elapsed_ms result from its own copy of the
// registers and checks every result strobe in order against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  localparam int Settle = 90;
  localparam int WatchLimit = 3000;

  typedef enum logic [1:0] {OP_STAMP, OP_WRITE, OP_QUIESCE} op_kind_t;
  typedef struct {
    op_kind_t           kind;
    tsms_pkg::reg_idx_t idx;
    logic [63:0]        data;
  } pending_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] raw_timestamp = '0;
  logic        done;
  logic [63:0] elapsed_ms;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  tsms_pkg::reg_idx_t cfg_index = tsms_pkg::REG_DIVISOR;
  logic [63:0] cfg_data = '0;

  pending_op_t pending[$];
  logic [63:0] expected_ms[$];

  logic [tsms_pkg::DivW-1:0]   freq_reg;
  logic                        mode_reg;
  logic [tsms_pkg::ScaleW-1:0] scale_reg;
  logic [63:0]                 origin_reg;

  int gap_cnt = 0;
  int quiet_cnt = 0;
  int idle_cnt = 0;
  int fail_cnt = 0;
  int stamps_sent = 0;
  int results_seen = 0;
  int writes_done = 0;
  bit no_gaps = 1'b0;

  timestamp_to_milliseconds dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] predict_ms(logic [63:0] stamp);
    logic [63:0] secs, frac, part;
    if (freq_reg == '0) begin
      secs = '1;
      frac = stamp;
    end else begin
      secs = stamp / {24'd0, freq_reg};
      frac = stamp % {24'd0, freq_reg};
    end
    if (mode_reg) begin
      part = (scale_reg == '0) ? '1 : frac / {33'd0, scale_reg};
    end else begin
      part = frac * {33'd0, scale_reg};
    end
    return secs * 64'd1000 + part - origin_reg;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk) begin
    logic st_n, cv_n;
    pending_op_t op;
    if (rst) begin
      freq_reg <= 40'd1;
      mode_reg <= 1'b0;
      scale_reg <= 31'd1;
      origin_reg <= '0;
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      st_n = start;
      cv_n = cfg_valid;
      if (start && !busy) begin
        expected_ms.push_back(predict_ms(raw_timestamp));
        stamps_sent++;
        st_n = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsms_pkg::REG_DIVISOR: freq_reg <= cfg_data[tsms_pkg::DivW-1:0];
          tsms_pkg::REG_MODE:    mode_reg <= cfg_data[0];
          tsms_pkg::REG_SCALE:   scale_reg <= cfg_data[tsms_pkg::ScaleW-1:0];
          tsms_pkg::REG_ORIGIN:  origin_reg <= cfg_data;
          default: ;
        endcase
        writes_done++;
        cv_n = 1'b0;
      end
      if (!st_n && !cv_n) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pending.size() > 0) begin
          op = pending[0];
          case (op.kind)
            OP_STAMP: begin
              void'(pending.pop_front());
              raw_timestamp <= op.data;
              st_n = 1'b1;
              gap_cnt = pick_gap();
            end
            OP_WRITE: begin
              void'(pending.pop_front());
              cfg_index <= op.idx;
              cfg_data <= op.data;
              cv_n = 1'b1;
            end
            default: begin
              if (expected_ms.size() == 0) begin
                if (quiet_cnt >= Settle) begin
                  void'(pending.pop_front());
                  quiet_cnt = 0;
                end else begin
                  quiet_cnt++;
                end
              end
            end
          endcase
        end
      end
      start <= st_n;
      cfg_valid <= cv_n;
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (expected_ms.size() == 0) begin
          $error("elapsed_ms: unexpected result %h", elapsed_ms);
          fail_cnt++;
        end else begin
          want = expected_ms.pop_front();
          if (elapsed_ms !== want) begin
            $error("elapsed_ms: expected %h actual %h", want, elapsed_ms);
            fail_cnt++;
          end
        end
      end
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic add_stamp(logic [63:0] v);
    pending.push_back('{OP_STAMP, tsms_pkg::REG_DIVISOR, v});
  endtask

  task automatic add_config(logic [39:0] freq, logic mode, logic [30:0] scale,
                            logic [63:0] origin);
    pending.push_back('{OP_QUIESCE, tsms_pkg::REG_DIVISOR, 64'd0});
    pending.push_back('{OP_WRITE, tsms_pkg::REG_DIVISOR,
                        {$urandom_range(0, 1) ? 24'd0 : 24'($urandom), freq}});
    pending.push_back('{OP_WRITE, tsms_pkg::REG_MODE, {63'($urandom) << 1, mode} >> 0});
    pending.push_back('{OP_WRITE, tsms_pkg::REG_SCALE, {33'($urandom), scale}});
    pending.push_back('{OP_WRITE, tsms_pkg::REG_ORIGIN, origin});
  endtask

  function automatic logic [63:0] rand_stamp(logic [39:0] freq);
    case ($urandom_range(0, 4))
      0: return {32'($urandom_range(0, 3000)), 32'($urandom)} ;
      1: return 64'($urandom_range(0, 100000));
      2: return 64'(freq) * $urandom_range(0, 5000) + $urandom_range(0, 2) - 1;
      3: return ~64'($urandom_range(0, 1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [39:0] freq;
    logic [30:0] scale;
    logic [63:0] origin;
    int r;
    add_stamp(64'd0);
    add_stamp('1);
    add_stamp(64'd1);
    add_stamp(64'h8000_0000_0000_0000);
    add_config(40'd1000, 1'b1, 31'd1, 64'd0);
    add_stamp(64'd999);
    add_stamp(64'd1000);
    add_stamp(64'd123_456_789);
    add_config('1, 1'b1, '1, 64'd5);
    add_stamp('1);
    add_stamp(64'hFF_FFFF_FFFE);
    add_stamp(64'd0);
    add_config(40'd0, 1'b0, 31'd3, 64'd0);
    add_stamp(64'd7);
    add_stamp('1);
    add_config(40'd3, 1'b1, 31'd0, '1);
    add_stamp(64'd2);
    add_stamp(64'd3);
    add_stamp('1);
    add_config(40'd1_000_000_000, 1'b0, '1, 64'h0123_4567_89AB_CDEF);
    add_stamp(64'd999_999_999);
    add_stamp('1);
    add_stamp(64'hDEAD_BEEF_CAFE_F00D);
    add_config('1, 1'b0, '1, '1);
    add_stamp(64'hFF_FFFF_FFFE);
    add_stamp('1);
    for (int ph = 0; ph < 13; ph++) begin
      r = $urandom_range(0, 9);
      freq = (r == 0) ? 40'd0 : (r < 4) ? 40'($urandom_range(1, 2000)) :
             (r < 7) ? 40'($urandom) : {8'($urandom), 32'($urandom)};
      r = $urandom_range(0, 9);
      scale = (r == 0) ? 31'd0 : (r < 5) ? 31'($urandom_range(1, 1000)) :
              31'($urandom);
      origin = $urandom_range(0, 1) ? 64'd0 : {$urandom, $urandom};
      add_config(freq, 1'($urandom), scale, origin);
      for (int i = 0; i < 100; i++) add_stamp(rand_stamp(freq));
    end
    add_config(40'd1, 1'b0, 31'd1, 64'd0);
    for (int i = 0; i < 30; i++) add_stamp(rand_stamp(40'd1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || start || cfg_valid || expected_ms.size() > 0) begin
      @(posedge clk);
      if (stamps_sent % 200 == 199) no_gaps = ~no_gaps;
    end
    repeat (Settle) @(posedge clk);
    $display("Converted %0d timestamps, checked %0d results, %0d register writes",
             stamps_sent, results_seen, writes_done);
    $display("Covered zero divisor, zero scale, both modes and wrapping origins");
    if (fail_cnt == 0 && expected_ms.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ timestamp_to_milliseconds.f @@
hw/rtl/tsms_pkg.sv
hw/rtl/timestamp_to_milliseconds.sv
sim/tb.sv
